@@ src/lpr_pkg.sv @@
package lpr_pkg;

  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned DivSteps  = 16;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  localparam logic [15:0] CeilingMargin = 16'h1999;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_GAIN_P         = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_I         = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_D         = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_ERROR_DIVISOR  = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_STEP_LIMIT     = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_POWER_RATIO    = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_JUMP_THRESHOLD = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_MODE      = 4'd7;

  localparam logic [15:0] GainPReset     = 16'd819;
  localparam logic [15:0] GainIReset     = 16'd0;
  localparam logic [15:0] GainDReset     = 16'd0;
  localparam logic [7:0]  DivisorReset   = 8'd4;
  localparam logic [15:0] StepLimitReset = 16'd40;
  localparam logic [15:0] RatioReset     = 16'd31596;
  localparam logic [15:0] ThresholdReset = 16'd1000;

  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SET_MUL,
    OP_SET_UPD,
    OP_TRACK,
    OP_JUMP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_ACC,
    OP_SCALE,
    OP_APPLY,
    OP_OUT
  } lpr_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SET_MUL,
    S_SET_UPD,
    S_TRACK,
    S_CHECK,
    S_DIV_INIT,
    S_DIV,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC,
    S_SCALE,
    S_APPLY,
    S_DONE
  } lpr_state_e;

  typedef struct packed {
    lpr_op_e op;
  } lpr_cmd_t;

  typedef struct packed {
    logic fault;    // fault latched
    logic changed;  // set item seen since the last tick that tracked the sample
    logic jump;     // sample moved more than the threshold
  } lpr_status_t;

endpackage

@@ src/laser_power_pid_regulator_top.sv @@
// Laser power regulator: an incremental PID loop on the drive current, fed by
// photodiode samples. A set item (tuser 0) loads the drive level, its ceiling
// and the target; a tick item (tuser 1) checks the feedback for a jump, which
// latches a fault until reset, and otherwise runs one PID step. The first tick
// after a set item takes its sample as the reference instead of checking it.
// While the fault is latched, ticks leave the level frozen; a set item still
// loads it. Each item returns one result. Items are taken one at a time; a
// tick runs the restoring divider of the error (16 iterations, one quotient
// bit each) and makes three passes through the single shared 17x20
// multiplier. The next item is taken while the previous result still waits
// in the output register. Configuration writes are always ready and must be
// issued only while the block is idle.
module laser_power_pid_regulator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lpr_pkg::CfgDataW-1:0]  cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lpr_pkg::InDataW-1:0]   s_axis_tdata,  // current_request[15:0], pd_sample[31:16]
  input  logic                          s_axis_tuser,  // func[0]
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // dac_code[14:0], drive_level[30:15], feedback_fault[31], regulating[32], zero pad
  output logic [lpr_pkg::OutDataW-1:0]  m_axis_tdata
);

  lpr_pkg::lpr_cmd_t    cmd;
  lpr_pkg::lpr_status_t status;
  logic                 cfg_xfer;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  lpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_func_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  lpr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_xfer),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_request_i (s_axis_tdata[15:0]),
    .in_sample_i  (s_axis_tdata[31:16]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_data_o   (m_axis_tdata)
  );

endmodule

@@ src/lpr_ctrl.sv @@
module lpr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_func_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lpr_pkg::lpr_cmd_t   cmd_o,
  input  lpr_pkg::lpr_status_t status_i
);

  lpr_pkg::lpr_state_e state_q, state_d;
  logic [lpr_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic in_xfer;
  logic out_load;

  localparam logic [lpr_pkg::DivCntW-1:0] DivLast = lpr_pkg::DivCntW'(lpr_pkg::DivSteps - 1);

  assign in_ready_o  = (state_q == lpr_pkg::S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpr_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o.op  = lpr_pkg::OP_NONE;
    out_load  = 1'b0;
    case (state_q)
      lpr_pkg::S_IDLE: begin
        if (in_xfer) begin
          cmd_o.op = lpr_pkg::OP_LOAD;
          if (in_func_i == lpr_pkg::FUNC_SET) begin
            state_d = lpr_pkg::S_SET_MUL;
          end else if (status_i.fault) begin
            state_d = lpr_pkg::S_DONE;
          end else if (status_i.changed) begin
            state_d = lpr_pkg::S_TRACK;
          end else begin
            state_d = lpr_pkg::S_CHECK;
          end
        end
      end
      lpr_pkg::S_SET_MUL: begin
        cmd_o.op = lpr_pkg::OP_SET_MUL;
        state_d  = lpr_pkg::S_SET_UPD;
      end
      lpr_pkg::S_SET_UPD: begin
        cmd_o.op = lpr_pkg::OP_SET_UPD;
        state_d  = lpr_pkg::S_DONE;
      end
      lpr_pkg::S_TRACK: begin
        cmd_o.op = lpr_pkg::OP_TRACK;
        state_d  = lpr_pkg::S_DIV_INIT;
      end
      lpr_pkg::S_CHECK: begin
        cmd_o.op = lpr_pkg::OP_JUMP;
        state_d  = status_i.jump ? lpr_pkg::S_DONE : lpr_pkg::S_DIV_INIT;
      end
      lpr_pkg::S_DIV_INIT: begin
        cmd_o.op = lpr_pkg::OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = lpr_pkg::S_DIV;
      end
      lpr_pkg::S_DIV: begin
        cmd_o.op = lpr_pkg::OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = lpr_pkg::S_MUL_P;
        end
      end
      lpr_pkg::S_MUL_P: begin
        cmd_o.op = lpr_pkg::OP_MUL_P;
        state_d  = lpr_pkg::S_MUL_I;
      end
      lpr_pkg::S_MUL_I: begin
        cmd_o.op = lpr_pkg::OP_MUL_I;
        state_d  = lpr_pkg::S_MUL_D;
      end
      lpr_pkg::S_MUL_D: begin
        cmd_o.op = lpr_pkg::OP_MUL_D;
        state_d  = lpr_pkg::S_ACC;
      end
      lpr_pkg::S_ACC: begin
        cmd_o.op = lpr_pkg::OP_ACC;
        state_d  = lpr_pkg::S_SCALE;
      end
      lpr_pkg::S_SCALE: begin
        cmd_o.op = lpr_pkg::OP_SCALE;
        state_d  = lpr_pkg::S_APPLY;
      end
      lpr_pkg::S_APPLY: begin
        cmd_o.op = lpr_pkg::OP_APPLY;
        state_d  = lpr_pkg::S_DONE;
      end
      lpr_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = lpr_pkg::OP_OUT;
          out_load = 1'b1;
          state_d  = lpr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lpr_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("new transfer taken while an item is in work");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpr_pkg::S_DIV) && (cnt_q == DivLast) |=> (state_q == lpr_pkg::S_MUL_P))
    else $error("divider did not hand over after its last step");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpr_pkg::S_DONE) && (!out_valid_q || out_ready_i)
    |=> out_valid_q && (state_q == lpr_pkg::S_IDLE))
    else $error("finished result not loaded into the output register");
`endif

endmodule

@@ src/lpr_datapath.sv @@
module lpr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [lpr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lpr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [15:0]                   in_request_i,
  input  logic [15:0]                   in_sample_i,
  input  lpr_pkg::lpr_cmd_t             cmd_i,
  output lpr_pkg::lpr_status_t          status_o,
  output logic [lpr_pkg::OutDataW-1:0]  out_data_o
);

  // configuration
  logic [15:0] gain_p_q, gain_i_q, gain_d_q, step_limit_q, ratio_q, threshold_q;
  logic [7:0]  divisor_q;
  logic        hold_mode_q;

  // loop state
  logic [15:0] target_q, level_q, ceiling_q, sample_last_q;
  logic signed [17:0] err_prev_q, err_prev2_q;
  logic        changed_q, fault_q;

  // item and work registers
  logic [15:0] request_q, sample_q;
  logic [7:0]  div_q, rem_q;
  logic [15:0] quo_q;
  logic        neg_q;
  logic signed [36:0] prod_q;
  logic signed [39:0] acc_q;
  logic [27:0] inc_mag_q;
  logic        inc_neg_q;
  logic [lpr_pkg::OutDataW-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= lpr_pkg::GainPReset;
      gain_i_q     <= lpr_pkg::GainIReset;
      gain_d_q     <= lpr_pkg::GainDReset;
      divisor_q    <= lpr_pkg::DivisorReset;
      step_limit_q <= lpr_pkg::StepLimitReset;
      ratio_q      <= lpr_pkg::RatioReset;
      threshold_q  <= lpr_pkg::ThresholdReset;
      hold_mode_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lpr_pkg::CFG_GAIN_P:         gain_p_q     <= cfg_data_i;
        lpr_pkg::CFG_GAIN_I:         gain_i_q     <= cfg_data_i;
        lpr_pkg::CFG_GAIN_D:         gain_d_q     <= cfg_data_i;
        lpr_pkg::CFG_ERROR_DIVISOR:  divisor_q    <= cfg_data_i[7:0];
        lpr_pkg::CFG_STEP_LIMIT:     step_limit_q <= cfg_data_i;
        lpr_pkg::CFG_POWER_RATIO:    ratio_q      <= cfg_data_i;
        lpr_pkg::CFG_JUMP_THRESHOLD: threshold_q  <= cfg_data_i;
        lpr_pkg::CFG_HOLD_MODE:      hold_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // error after the divider, and the sums the integral and derivative terms use
  logic signed [17:0] err_w;
  logic signed [19:0] err20, prev20, prev2_20, sum_i, sum_d;
  assign err_w    = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
  assign err20    = 20'(err_w);
  assign prev20   = 20'(err_prev_q);
  assign prev2_20 = 20'(err_prev2_q);
  assign sum_i    = err20 + prev20 + prev2_20;
  assign sum_d    = err20 - (prev20 <<< 1) + prev2_20;

  // shared multiplier
  logic signed [16:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [36:0] prod_d;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      lpr_pkg::OP_SET_MUL: begin
        mul_a = $signed({1'b0, ratio_q});
        mul_b = $signed({4'b0000, request_q});
      end
      lpr_pkg::OP_MUL_P: begin
        mul_a = $signed({1'b0, gain_p_q});
        mul_b = err20;
      end
      lpr_pkg::OP_MUL_I: begin
        mul_a = $signed({1'b0, gain_i_q});
        mul_b = sum_i;
      end
      lpr_pkg::OP_MUL_D: begin
        mul_a = $signed({1'b0, gain_d_q});
        mul_b = sum_d;
      end
      default: ;
    endcase
  end
  assign prod_d = 37'(mul_a * mul_b);

  // set item
  logic [16:0] ceil_sum;
  logic [15:0] ceil_new, target_new;
  assign ceil_sum   = {1'b0, request_q} + {1'b0, lpr_pkg::CeilingMargin};
  assign ceil_new   = ceil_sum[16] ? 16'hFFFF : ceil_sum[15:0];
  assign target_new = hold_mode_q ? sample_q
                    : ((prod_q[31:28] != 4'd0) ? 16'hFFFF : prod_q[27:12]);

  // feedback jump
  logic [15:0] delta;
  assign delta = (sample_q > sample_last_q) ? (sample_q - sample_last_q)
                                            : (sample_last_q - sample_q);

  // divider setup and step
  logic signed [16:0] diff;
  logic [16:0] diff_abs;
  logic [8:0]  trial, trial_sub;
  logic        trial_ge;
  assign diff      = $signed({1'b0, target_q}) - $signed({1'b0, sample_q});
  assign diff_abs  = diff[16] ? 17'(-diff) : 17'(diff);
  assign trial     = {rem_q, quo_q[15]};
  assign trial_ge  = trial >= {1'b0, div_q};
  assign trial_sub = trial - {1'b0, div_q};

  // increment scaling, clamp and level update
  logic signed [39:0] acc_abs;
  logic [15:0] lim_mag;
  logic signed [17:0] inc18, lvl18;
  logic [15:0] lvl_new;
  assign acc_abs = acc_q[39] ? -acc_q : acc_q;
  assign lim_mag = (inc_mag_q > {12'd0, step_limit_q}) ? step_limit_q : inc_mag_q[15:0];
  assign inc18   = inc_neg_q ? -$signed({2'b00, lim_mag}) : $signed({2'b00, lim_mag});
  assign lvl18   = $signed({2'b00, level_q}) + inc18;
  always_comb begin
    if (lvl18 < 0) begin
      lvl_new = '0;
    end else if (lvl18 > $signed({2'b00, ceiling_q})) begin
      lvl_new = ceiling_q;
    end else begin
      lvl_new = lvl18[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q      <= '0;
      level_q       <= '0;
      ceiling_q     <= '0;
      sample_last_q <= '0;
      err_prev_q    <= '0;
      err_prev2_q   <= '0;
      changed_q     <= 1'b0;
      fault_q       <= 1'b0;
    end else begin
      case (cmd_i.op)
        lpr_pkg::OP_SET_UPD: begin
          level_q   <= request_q;
          ceiling_q <= ceil_new;
          target_q  <= target_new;
          changed_q <= 1'b1;
        end
        lpr_pkg::OP_TRACK: begin
          changed_q     <= 1'b0;
          sample_last_q <= sample_q;
        end
        lpr_pkg::OP_JUMP: begin
          sample_last_q <= sample_q;
          if (delta > threshold_q) begin
            fault_q <= 1'b1;
          end
        end
        lpr_pkg::OP_APPLY: begin
          level_q     <= lvl_new;
          err_prev2_q <= err_prev_q;
          err_prev_q  <= err_w;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      lpr_pkg::OP_LOAD: begin
        request_q <= in_request_i;
        sample_q  <= in_sample_i;
      end
      lpr_pkg::OP_SET_MUL: prod_q <= prod_d;
      lpr_pkg::OP_DIV_INIT: begin
        div_q <= (divisor_q == 8'd0) ? 8'd1 : divisor_q;
        rem_q <= '0;
        quo_q <= diff_abs[15:0];
        neg_q <= diff[16];
      end
      lpr_pkg::OP_DIV_STEP: begin
        rem_q <= trial_ge ? trial_sub[7:0] : trial[7:0];
        quo_q <= {quo_q[14:0], trial_ge};
      end
      lpr_pkg::OP_MUL_P: prod_q <= prod_d;
      lpr_pkg::OP_MUL_I: begin
        prod_q <= prod_d;
        acc_q  <= 40'(prod_q);
      end
      lpr_pkg::OP_MUL_D: begin
        prod_q <= prod_d;
        acc_q  <= acc_q + 40'(prod_q);
      end
      lpr_pkg::OP_ACC:   acc_q <= acc_q + 40'(prod_q);
      lpr_pkg::OP_SCALE: begin
        inc_mag_q <= acc_abs[39:12];
        inc_neg_q <= acc_q[39];
      end
      lpr_pkg::OP_OUT:   out_q <= {7'd0, !fault_q, fault_q, level_q, level_q[15:1]};
      default: ;
    endcase
  end

  assign status_o.fault   = fault_q;
  assign status_o.changed = changed_q;
  assign status_o.jump    = delta > threshold_q;
  assign out_data_o       = out_q;

`ifndef SYNTHESIS
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q |=> fault_q)
    else $error("latched feedback fault was cleared");

  a_level_ceiling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == lpr_pkg::OP_APPLY) |=> (level_q <= ceiling_q))
    else $error("regulated level above its ceiling");

  a_fault_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q && (cmd_i.op != lpr_pkg::OP_SET_UPD) |=> $stable(level_q))
    else $error("level moved while the feedback fault is latched");
`endif

endmodule
